/* rtl/core/ypc_pkg.sv */
// Shared constants, control struct and helpers for the yaw/pitch camera pose unit.
package ypc_pkg;

  localparam int ANGLE_BITS_DEF = 16;

  localparam int MUL_AW  = 50;
  localparam int MUL_BW  = 18;
  localparam int MUL_ACW = 68;

  localparam int POLY_A = 102944;
  localparam int POLY_B = 42047;
  localparam int POLY_C = 4640;

  localparam logic signed [MUL_ACW-1:0] SAT_HI = MUL_ACW'(64'sd2147483647);
  localparam logic signed [MUL_ACW-1:0] SAT_LO = -MUL_ACW'(64'sd2147483648);

  typedef struct packed {
    logic start;
    logic keep;
    logic neg;
  } mul_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [MUL_ACW-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/ypc_smul.sv */
// Bit-serial signed multiply-accumulate unit, one multiplier bit per cycle.
module ypc_smul #(
  parameter int AW  = ypc_pkg::MUL_AW,
  parameter int BW  = ypc_pkg::MUL_BW,
  parameter int ACW = ypc_pkg::MUL_ACW
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ypc_pkg::mul_ctl_t      ctl,
  input  logic signed [AW-1:0]   a_i,
  input  logic signed [BW-1:0]   b_i,
  input  logic signed [ACW-1:0]  init_i,
  output logic                   done_o,
  output logic signed [ACW-1:0]  acc_o
);

  localparam int CW = $clog2(BW);

  logic                  busy_r;
  logic                  done_r;
  logic [CW-1:0]         cnt_r;
  logic signed [ACW-1:0] a_r;
  logic [BW-1:0]         b_r;
  logic signed [ACW-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        a_r    <= ctl.neg ? -ACW'(a_i) : ACW'(a_i);
        b_r    <= b_i;
        cnt_r  <= '0;
        busy_r <= 1'b1;
        if (!ctl.keep) begin
          acc_r <= init_i;
        end
      end else if (busy_r) begin
        // top bit of the multiplier carries negative weight
        if (b_r[0]) begin
          acc_r <= (cnt_r == CW'(BW-1)) ? acc_r - a_r : acc_r + a_r;
        end
        a_r   <= a_r <<< 1;
        b_r   <= b_r >> 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(BW-1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_r;
  assign acc_o  = acc_r;

endmodule

/* rtl/core/yaw_pitch_camera_pose_unit.sv */
// Top level: camera pose state, sequencer and view-matrix row output.
//
// Input channel (in_*): one beat per item. tuser = kind (0 move, 1 set pose),
// tdata = x, y, z (Q16.16), yaw, pitch (binary angles).
// Output channel (out_*): three beats per item, view matrix rows 0..2;
// tlast marks row 2. Row 3 is always 0 0 0 1 and is not sent.
// All products run through one bit-serial multiplier; a set-pose item uses
// 28 products, a move item 36 products.
// A new item is taken only when the sequencer is idle; a finished row 2
// may still sit in the output register at that time.
// When the receiver stalls, the sequencer holds before loading the next
// row until the output register is free.
// Reset (rst_n low, synchronous) clears position and angles to zero,
// cosines to 32767 and sines to zero, and empties the output register.
module yaw_pitch_camera_pose_unit #(
  parameter int ANGLE_BITS = ypc_pkg::ANGLE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // in_x, in_y, in_z, in_yaw, in_pitch
  input  logic         in_tuser,   // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [87:0]  out_tdata,  // row, m_col0, m_col1, m_col2, m_offset, zero pad
  output logic         out_tlast
);

  localparam int AB  = ANGLE_BITS;
  localparam int EW  = ((AB > 16) ? AB : 16) + 2;
  localparam int AW  = ypc_pkg::MUL_AW;
  localparam int BW  = ypc_pkg::MUL_BW;
  localparam int ACW = ypc_pkg::MUL_ACW;

  localparam logic [AB-1:0]        QTR  = {2'b01, {(AB-2){1'b0}}};
  localparam logic signed [EW-1:0] PMAX = EW'(QTR);
  localparam logic signed [EW-1:0] PMIN = -EW'(QTR);
  localparam logic signed [ACW-1:0] RND15 = ACW'(16384);
  localparam logic signed [ACW-1:0] RND30 = ACW'(64'sd536870912);

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_EMIT} state_t;

  typedef enum logic [4:0] {
    OP_Z2, OP_T1, OP_T2, OP_S,
    OP_IN0, OP_IN1, OP_DX0, OP_DX1, OP_DZ0, OP_DZ1, OP_DY0, OP_DY1,
    OP_M10, OP_M12, OP_M20, OP_M22,
    OP_R0A, OP_R0B, OP_R1A, OP_R1B, OP_R1C, OP_R2A, OP_R2B, OP_R2C
  } op_t;

  state_t             st_r;
  op_t                op_r;
  logic [1:0]         ang_r;
  logic [1:0]         row_r;
  logic               move_r;
  logic signed [31:0] vx_r, vy_r, vz_r;
  logic [AB-1:0]      yaw_r;
  logic signed [AB-1:0] pitch_r;
  logic signed [15:0] ys_r, yc_r, ps_r, pc_r;
  logic signed [15:0] m10_r, m12_r, m20_r, m22_r;
  logic [16:0]        z2_r;
  logic [BW-1:0]      t_r;
  logic signed [AW-1:0] inner_r;
  logic signed [31:0] px_r, py_r, pz_r;
  logic signed [31:0] off_r;

  logic               out_valid_r;
  logic [1:0]         o_row_r;
  logic signed [15:0] o_c0_r, o_c1_r, o_c2_r;
  logic signed [31:0] o_off_r;

  ypc_pkg::mul_ctl_t    mctl;
  logic signed [AW-1:0] a_op;
  logic signed [BW-1:0] b_op;
  logic signed [ACW-1:0] init_op;
  logic                 mdone;
  logic signed [ACW-1:0] acc;

  ypc_smul #(.AW(AW), .BW(BW), .ACW(ACW)) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mctl),
    .a_i    (a_op),
    .b_i    (b_op),
    .init_i (init_op),
    .done_o (mdone),
    .acc_o  (acc)
  );

  // angle reduction for the sine being evaluated
  logic [AB-1:0]  ang_sel;
  logic [1:0]     quad;
  logic [AB-2:0]  xm;
  logic [AB+14:0] zw;
  logic [16:0]    z;
  logic [BW-1:0]  s_w, q_w;
  logic signed [15:0] qs, sin_v;

  always_comb begin
    case (ang_r)
      2'd0:    ang_sel = yaw_r;
      2'd1:    ang_sel = yaw_r + QTR;
      2'd2:    ang_sel = pitch_r;
      default: ang_sel = pitch_r + QTR;
    endcase
    quad = ang_sel[AB-1:AB-2];
    xm   = quad[0] ? (QTR[AB-2:0] - {1'b0, ang_sel[AB-3:0]}) : {1'b0, ang_sel[AB-3:0]};
    zw   = {xm, 16'b0} >> (AB-2);
    z    = zw[16:0];
    s_w  = acc[33:16];
    q_w  = (s_w + 1'b1) >> 1;
    qs   = (q_w > BW'(32767)) ? 16'sd32767 : signed'(q_w[15:0]);
    sin_v = quad[1] ? -qs : qs;
  end

  // pose update on an accepted beat
  logic signed [31:0]   in_x, in_y, in_z;
  logic signed [15:0]   in_yaw, in_pitch;
  logic signed [EW-1:0] ydel, pbase, psum, pcl;
  logic [AB-1:0]        yaw_nxt;

  always_comb begin
    in_x     = signed'(in_tdata[31:0]);
    in_y     = signed'(in_tdata[63:32]);
    in_z     = signed'(in_tdata[95:64]);
    in_yaw   = signed'(in_tdata[111:96]);
    in_pitch = signed'(in_tdata[127:112]);
    ydel     = EW'(in_yaw);
    yaw_nxt  = (in_tuser ? '0 : yaw_r) + ydel[AB-1:0];
    pbase    = in_tuser ? '0 : EW'(pitch_r);
    psum     = pbase + EW'(in_pitch);
    if (psum > PMAX) begin
      pcl = PMAX;
    end else if (psum < PMIN) begin
      pcl = PMIN;
    end else begin
      pcl = psum;
    end
  end

  // operand selection
  always_comb begin
    mctl.start = (st_r == ST_ISSUE);
    mctl.keep  = 1'b0;
    mctl.neg   = 1'b0;
    a_op       = '0;
    b_op       = '0;
    init_op    = '0;
    case (op_r)
      OP_Z2: begin a_op = AW'(z); b_op = BW'(z); end
      OP_T1: begin a_op = AW'(z2_r); b_op = BW'(ypc_pkg::POLY_C); end
      OP_T2: begin a_op = AW'(z2_r); b_op = t_r; end
      OP_S:  begin a_op = AW'(z); b_op = t_r; end
      OP_IN0: begin a_op = AW'(vy_r); b_op = BW'(ps_r); end
      OP_IN1: begin a_op = AW'(vz_r); b_op = BW'(pc_r); mctl.keep = 1'b1; end
      OP_DX0: begin a_op = AW'(vx_r) <<< 15; b_op = BW'(yc_r); init_op = RND30; end
      OP_DX1: begin a_op = inner_r; b_op = BW'(ys_r); mctl.keep = 1'b1; end
      OP_DZ0: begin
        a_op = AW'(vx_r) <<< 15; b_op = BW'(ys_r); init_op = RND30; mctl.neg = 1'b1;
      end
      OP_DZ1: begin a_op = inner_r; b_op = BW'(yc_r); mctl.keep = 1'b1; end
      OP_DY0: begin a_op = AW'(vy_r); b_op = BW'(pc_r); init_op = RND15; end
      OP_DY1: begin
        a_op = AW'(vz_r); b_op = BW'(ps_r); mctl.keep = 1'b1; mctl.neg = 1'b1;
      end
      OP_M10: begin a_op = AW'(ps_r); b_op = BW'(ys_r); init_op = RND15; end
      OP_M12: begin a_op = AW'(ps_r); b_op = BW'(yc_r); init_op = RND15; end
      OP_M20: begin a_op = AW'(pc_r); b_op = BW'(ys_r); init_op = RND15; end
      OP_M22: begin a_op = AW'(pc_r); b_op = BW'(yc_r); init_op = RND15; end
      OP_R0A: begin
        a_op = AW'(px_r); b_op = BW'(yc_r); init_op = RND15; mctl.neg = 1'b1;
      end
      OP_R0B: begin a_op = AW'(pz_r); b_op = BW'(ys_r); mctl.keep = 1'b1; end
      OP_R1A: begin
        a_op = AW'(px_r); b_op = BW'(m10_r); init_op = RND15; mctl.neg = 1'b1;
      end
      OP_R1B: begin
        a_op = AW'(py_r); b_op = BW'(pc_r); mctl.keep = 1'b1; mctl.neg = 1'b1;
      end
      OP_R1C: begin
        a_op = AW'(pz_r); b_op = BW'(m12_r); mctl.keep = 1'b1; mctl.neg = 1'b1;
      end
      OP_R2A: begin
        a_op = AW'(px_r); b_op = BW'(m20_r); init_op = RND15; mctl.neg = 1'b1;
      end
      OP_R2B: begin a_op = AW'(py_r); b_op = BW'(ps_r); mctl.keep = 1'b1; end
      OP_R2C: begin
        a_op = AW'(pz_r); b_op = BW'(m22_r); mctl.keep = 1'b1; mctl.neg = 1'b1;
      end
      default: begin a_op = '0; b_op = '0; end
    endcase
  end

  logic out_free;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (st_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      op_r        <= OP_Z2;
      ang_r       <= 2'd0;
      row_r       <= 2'd0;
      out_valid_r <= 1'b0;
      px_r        <= '0;
      py_r        <= '0;
      pz_r        <= '0;
      yaw_r       <= '0;
      pitch_r     <= '0;
      yc_r        <= 16'sd32767;
      ys_r        <= '0;
      pc_r        <= 16'sd32767;
      ps_r        <= '0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            move_r  <= !in_tuser;
            vx_r    <= in_x;
            vy_r    <= in_y;
            vz_r    <= in_z;
            yaw_r   <= yaw_nxt;
            pitch_r <= pcl[AB-1:0];
            if (in_tuser) begin
              px_r <= in_x;
              py_r <= in_y;
              pz_r <= in_z;
            end
            ang_r <= 2'd0;
            op_r  <= OP_Z2;
            st_r  <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          st_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (mdone) begin
            st_r <= ST_ISSUE;
            case (op_r)
              OP_Z2: begin z2_r <= acc[32:16]; op_r <= OP_T1; end
              OP_T1: begin
                t_r <= BW'(ypc_pkg::POLY_B) - BW'(acc[32:16]); op_r <= OP_T2;
              end
              OP_T2: begin
                t_r <= BW'(ypc_pkg::POLY_A) - acc[33:16]; op_r <= OP_S;
              end
              OP_S: begin
                case (ang_r)
                  2'd0:    ys_r <= sin_v;
                  2'd1:    yc_r <= sin_v;
                  2'd2:    ps_r <= sin_v;
                  default: pc_r <= sin_v;
                endcase
                if (ang_r != 2'd3) begin
                  ang_r <= ang_r + 2'd1;
                  op_r  <= OP_Z2;
                end else begin
                  op_r <= move_r ? OP_IN0 : OP_M10;
                end
              end
              OP_IN0: op_r <= OP_IN1;
              OP_IN1: begin inner_r <= acc[AW-1:0]; op_r <= OP_DX0; end
              OP_DX0: op_r <= OP_DX1;
              OP_DX1: begin
                px_r <= ypc_pkg::sat32(ACW'(px_r) + (acc >>> 30)); op_r <= OP_DZ0;
              end
              OP_DZ0: op_r <= OP_DZ1;
              OP_DZ1: begin
                pz_r <= ypc_pkg::sat32(ACW'(pz_r) + (acc >>> 30)); op_r <= OP_DY0;
              end
              OP_DY0: op_r <= OP_DY1;
              OP_DY1: begin
                py_r <= ypc_pkg::sat32(ACW'(py_r) + (acc >>> 15)); op_r <= OP_M10;
              end
              OP_M10: begin m10_r <= acc[30:15]; op_r <= OP_M12; end
              OP_M12: begin m12_r <= acc[30:15]; op_r <= OP_M20; end
              OP_M20: begin m20_r <= acc[30:15]; op_r <= OP_M22; end
              OP_M22: begin m22_r <= acc[30:15]; op_r <= OP_R0A; end
              OP_R0A: op_r <= OP_R0B;
              OP_R0B: begin
                off_r <= ypc_pkg::sat32(acc >>> 15);
                row_r <= 2'd0;
                op_r  <= OP_R1A;
                st_r  <= ST_EMIT;
              end
              OP_R1A: op_r <= OP_R1B;
              OP_R1B: op_r <= OP_R1C;
              OP_R1C: begin
                off_r <= ypc_pkg::sat32(acc >>> 15);
                row_r <= 2'd1;
                op_r  <= OP_R2A;
                st_r  <= ST_EMIT;
              end
              OP_R2A: op_r <= OP_R2B;
              OP_R2B: op_r <= OP_R2C;
              OP_R2C: begin
                off_r <= ypc_pkg::sat32(acc >>> 15);
                row_r <= 2'd2;
                st_r  <= ST_EMIT;
              end
              default: st_r <= ST_IDLE;
            endcase
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            o_row_r     <= row_r;
            o_off_r     <= off_r;
            case (row_r)
              2'd0: begin
                o_c0_r <= yc_r; o_c1_r <= '0; o_c2_r <= -ys_r;
              end
              2'd1: begin
                o_c0_r <= m10_r; o_c1_r <= pc_r; o_c2_r <= m12_r;
              end
              default: begin
                o_c0_r <= m20_r; o_c1_r <= -ps_r; o_c2_r <= m22_r;
              end
            endcase
            st_r <= (row_r == 2'd2) ? ST_IDLE : ST_ISSUE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, o_off_r, o_c2_r, o_c1_r, o_c0_r, o_row_r};
  assign out_tlast  = (o_row_r == 2'd2);

endmodule
